// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the Hamming SEC codec.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/hsc_pkg.sv =====
// Package of the Hamming SEC codec: widths, types, size tables and parity helpers.
// No dependencies.
package hsc_pkg;

  localparam int DATA_W = 64;
  localparam int CODE_W = 71;
  localparam int SYN_W  = 7;
  localparam int SEL_W  = 3;
  localparam int HIGH_W = CODE_W - DATA_W;

  typedef logic [SEL_W-1:0]  sel_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SYN_W-1:0]  syn_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic [SEL_W-1:0] {
    SIZE_8  = 3'd0,
    SIZE_12 = 3'd1,
    SIZE_16 = 3'd2,
    SIZE_24 = 3'd3,
    SIZE_32 = 3'd4,
    SIZE_48 = 3'd5,
    SIZE_64 = 3'd6,
    SIZE_64_ALT = 3'd7
  } size_sel_t;

  localparam sel_t SEL_RESET = SIZE_64;

  // Decoder status handed to the result stage.
  typedef struct packed {
    syn_t syndrome;
    logic corrected;
    logic bad_syndrome;
  } dec_status_t;

  // Codeword length for a size code; the spare code saturates to the largest size.
  function automatic syn_t code_len(input sel_t sel);
    syn_t n;
    case (sel)
      SIZE_8:  n = 7'd12;
      SIZE_12: n = 7'd17;
      SIZE_16: n = 7'd21;
      SIZE_24: n = 7'd29;
      SIZE_32: n = 7'd38;
      SIZE_48: n = 7'd54;
      default: n = 7'd71;
    endcase
    return n;
  endfunction

  function automatic syn_t data_len(input sel_t sel);
    syn_t d;
    case (sel)
      SIZE_8:  d = 7'd8;
      SIZE_12: d = 7'd12;
      SIZE_16: d = 7'd16;
      SIZE_24: d = 7'd24;
      SIZE_32: d = 7'd32;
      SIZE_48: d = 7'd48;
      default: d = 7'd64;
    endcase
    return d;
  endfunction

  // One bit per codeword position inside the configured length.
  function automatic code_t code_mask(input sel_t sel);
    code_t mask;
    syn_t  n;
    int    i;
    n = code_len(sel);
    for (i = 0; i < CODE_W; i++) begin
      mask[i] = (SYN_W'(i) < n);
    end
    return mask;
  endfunction

  function automatic data_t data_mask(input sel_t sel);
    data_t mask;
    syn_t  d;
    int    i;
    d = data_len(sel);
    for (i = 0; i < DATA_W; i++) begin
      mask[i] = (SYN_W'(i) < d);
    end
    return mask;
  endfunction

  // Bit index (position - 1) in the codeword of data bit k.
  function automatic syn_t data_idx(input int k);
    syn_t res;
    int   cnt;
    int   p;
    res = '0;
    cnt = 0;
    for (p = 1; p <= CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == k) res = SYN_W'(p - 1);
        cnt++;
      end
    end
    return res;
  endfunction

  // Positions whose number has bit m set.
  function automatic code_t pos_mask(input int m);
    code_t mask;
    syn_t  pos;
    int    i;
    for (i = 0; i < CODE_W; i++) begin
      pos     = SYN_W'(i + 1);
      mask[i] = pos[m];
    end
    return mask;
  endfunction

  // Syndrome: XOR of the numbers of all set positions, one parity tree per bit.
  function automatic syn_t syndrome_of(input code_t w);
    syn_t s;
    int   m;
    for (m = 0; m < SYN_W; m++) begin
      s[m] = ^(w & pos_mask(m));
    end
    return s;
  endfunction

endpackage

// ===== rtl/hsc_if.sv =====
// Request and result channel interfaces of the Hamming SEC codec.
// Depends on hsc_pkg.
interface hsc_in_if;
  import hsc_pkg::*;
  logic  valid;
  logic  ready;
  logic  op;
  data_t data_word;
  data_t code_low;
  logic [HIGH_W-1:0] code_high;

  modport source (output valid, op, data_word, code_low, code_high, input ready);
  modport sink   (input valid, op, data_word, code_low, code_high, output ready);
endinterface

interface hsc_out_if;
  import hsc_pkg::*;
  logic  valid;
  logic  ready;
  data_t data_out;
  data_t code_out_low;
  logic [HIGH_W-1:0] code_out_high;
  syn_t  syndrome;
  logic  corrected;
  logic  bad_syndrome;

  modport source (output valid, data_out, code_out_low, code_out_high, syndrome,
                  corrected, bad_syndrome, input ready);
  modport sink   (input valid, data_out, code_out_low, code_out_high, syndrome,
                  corrected, bad_syndrome, output ready);
endinterface

// ===== rtl/hsc_encode.sv =====
// Hamming SEC encoder: spreads data bits over the codeword and fills the parity positions.
// Depends on hsc_pkg.
module hsc_encode (
  input  hsc_pkg::sel_t  sel,
  input  hsc_pkg::data_t data_word,
  output hsc_pkg::code_t code
);
  import hsc_pkg::*;

  data_t din;
  code_t spread;
  code_t parity;
  syn_t  par;

  // drop data bits above the block size
  assign din = data_word & data_mask(sel);

  for (genvar i = 0; i < CODE_W; i++) begin : g_clr
    if ((i & (i + 1)) == 0) begin : g_par
      assign spread[i] = 1'b0;
    end
  end
  for (genvar k = 0; k < DATA_W; k++) begin : g_spread
    assign spread[data_idx(k)] = din[k];
  end

  // parity bits beyond the codeword come out zero on their own
  assign par = syndrome_of(spread);

  always_comb begin
    parity = '0;
    for (int m = 0; m < SYN_W; m++) begin
      parity[(1 << m) - 1] = par[m];
    end
  end

  assign code = spread | parity;

endmodule

// ===== rtl/hsc_decode.sv =====
// Hamming SEC decoder: syndrome, single-bit correction and data extraction.
// Depends on hsc_pkg.
module hsc_decode (
  input  hsc_pkg::sel_t        sel,
  input  hsc_pkg::code_t       code,
  output hsc_pkg::data_t       data,
  output hsc_pkg::dec_status_t status
);
  import hsc_pkg::*;

  code_t masked;
  code_t fixed;
  code_t flip;
  syn_t  syn;
  syn_t  n;
  logic  bad;
  logic  corr;

  assign masked = code & code_mask(sel);
  assign syn    = syndrome_of(masked);
  assign n      = code_len(sel);
  assign bad    = (syn > n);
  assign corr   = (syn != '0) && !bad;

  for (genvar i = 0; i < CODE_W; i++) begin : g_flip
    assign flip[i] = corr && (syn == SYN_W'(i + 1));
  end

  assign fixed = masked ^ flip;

  for (genvar k = 0; k < DATA_W; k++) begin : g_extract
    assign data[k] = fixed[data_idx(k)];
  end

  assign status.syndrome     = syn;
  assign status.corrected    = corr;
  assign status.bad_syndrome = bad;

endmodule

// ===== rtl/hamming_sec_codec_variable_block.sv =====
// Top level of the Hamming SEC codec with selectable block size.
// Depends on hsc_pkg, hsc_if, hsc_encode, hsc_decode and assert_macros.svh.
//
// Usage:
//   in_ch  : request channel (valid/ready). op selects encode (data_word) or
//            decode (code_low holds positions 1..64, code_high 65..71).
//   out_ch : result channel (valid/ready), one result per request. Fields
//            that do not belong to the operation are zero.
//   cfg_we / cfg_wdata : block size code (8,12,16,24,32,48,64 data bits);
//            write it only while no request is in flight.
// Path: an accepted request goes to the request register, then through the
//   parity trees and correction into the result register. Throughput: one
//   request per cycle while out_ch.ready stays high, set by the single pass
//   through the parity trees between the two registers.
// Stall: when out_ch.ready is low the result register holds; the request
//   register still takes one more request, so in_ch.ready drops only when
//   both registers are full.
// Reset (synchronous, rst_n low): both stages empty, block size 64 bits.
`include "assert_macros.svh"

module hamming_sec_codec_variable_block (
  input  logic          clk,
  input  logic          rst_n,
  hsc_in_if.sink        in_ch,
  hsc_out_if.source     out_ch,
  input  logic          cfg_we,
  input  hsc_pkg::sel_t cfg_wdata
);
  import hsc_pkg::*;

  // Configuration register
  sel_t sel_r;
  sel_t sel_nxt;

  // Request stage
  logic  s1_valid_r, s1_valid_nxt;
  logic  s1_op_r;
  code_t s1_code_r;
  data_t s1_data_r;

  // Result stage
  logic  out_valid_r, out_valid_nxt;
  data_t out_data_r;
  code_t out_code_r;
  dec_status_t out_status_r;

  logic in_acc;
  logic out_adv;
  logic s1_adv;

  code_t enc_code;
  data_t dec_data;
  dec_status_t dec_status;

  // Handshake: the result register frees up when empty or being taken.
  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign sel_nxt       = cfg_we ? cfg_wdata : sel_r;
  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= SEL_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_ch.op;
      s1_data_r <= in_ch.data_word;
      s1_code_r <= {in_ch.code_high, in_ch.code_low};
    end
  end

  hsc_encode u_enc (
    .sel       (sel_r),
    .data_word (s1_data_r),
    .code      (enc_code)
  );

  hsc_decode u_dec (
    .sel    (sel_r),
    .code   (s1_code_r),
    .data   (dec_data),
    .status (dec_status)
  );

  // Load the result, zeroing the fields of the other operation
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_op_r == OP_DECODE) begin
        out_data_r   <= dec_data;
        out_code_r   <= '0;
        out_status_r <= dec_status;
      end else begin
        out_data_r   <= '0;
        out_code_r   <= enc_code;
        out_status_r <= '0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_out      = out_data_r;
  assign out_ch.code_out_low  = out_code_r[DATA_W-1:0];
  assign out_ch.code_out_high = out_code_r[CODE_W-1:DATA_W];
  assign out_ch.syndrome      = out_status_r.syndrome;
  assign out_ch.corrected     = out_status_r.corrected;
  assign out_ch.bad_syndrome  = out_status_r.bad_syndrome;

  // Correction and the out-of-range flag exclude each other
  `ASSERT_IMPLY(a_corr_bad_excl, clk, rst_n, out_valid_r, !(out_status_r.corrected && out_status_r.bad_syndrome))
  // Either flag implies a nonzero syndrome
  `ASSERT_IMPLY(a_flag_syn, clk, rst_n, out_valid_r && (out_status_r.corrected || out_status_r.bad_syndrome), out_status_r.syndrome != '0)
  // A request leaving the first stage lands in the result register
  `ASSERT_NEXT(a_s1_to_out, clk, rst_n, s1_adv, out_valid_r)
  // An accepted request occupies the first stage next cycle
  `ASSERT_NEXT(a_acc_s1, clk, rst_n, in_acc, s1_valid_r)

endmodule
